/* hw/rtl/pfa_pkg.sv */
// Shared types and constants for the packed field array.
// Used by every module under hw/rtl but pfa_bank; depends on nothing.
package pfa_pkg;

  localparam int WORD_W         = 32;
  localparam int VALUE_W        = 31;
  localparam int INDEX_W        = 15;
  localparam int COUNT_W        = 16;
  localparam int FWIDTH_W       = 5;
  localparam int POS_W          = INDEX_W + FWIDTH_W;
  localparam int DEF_WORD_DEPTH = 1024;

  localparam logic [COUNT_W-1:0]  MAX_FIELDS        = 16'd32768;
  localparam logic [FWIDTH_W-1:0] RESET_FIELD_WIDTH = 5'd8;

  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } pfa_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    status_t            status;
    logic [COUNT_W-1:0] field_count;
  } pfa_rsp_t;

  // side information carried alongside the bank read data
  typedef struct packed {
    logic                extract;
    logic                odd;
    logic                hi_ok;
    logic                lo_ok;
    logic [4:0]          off;
    logic [FWIDTH_W-1:0] fw;
    status_t             status;
    logic [COUNT_W-1:0]  count;
  } pfa_info_t;

endpackage

/* hw/rtl/pfa_bank.sv */
// One bank of packed words: one write port, one registered read port.
// Depends on nothing but its parameters.
module pfa_bank #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/pfa_issue.sv */
// Request stage: fill state, field width register, append packing and
// bank address generation for reads. Depends on pfa_pkg.
module pfa_issue
  import pfa_pkg::*;
#(
  parameter int WORD_DEPTH = DEF_WORD_DEPTH,
  parameter int BANK_AW    = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [FWIDTH_W-1:0] cfg_write_data,
  input  pfa_req_t            req,
  input  logic                fire,
  output logic                even_we,
  output logic [BANK_AW-1:0]  even_waddr,
  output logic [31:0]         even_wdata,
  output logic                odd_we,
  output logic [BANK_AW-1:0]  odd_waddr,
  output logic [31:0]         odd_wdata,
  output logic                rd_en,
  output logic [BANK_AW-1:0]  even_raddr,
  output logic [BANK_AW-1:0]  odd_raddr,
  output pfa_info_t           info
);

  localparam int WAW    = $clog2(WORD_DEPTH);
  localparam int FILL_W = WAW + 6;
  localparam logic [FILL_W:0] CAPACITY = (FILL_W+1)'(WORD_DEPTH * 32);
  localparam logic [16:0]     DEPTH_17 = 17'(WORD_DEPTH);

  logic [FWIDTH_W-1:0] field_width;
  logic [FILL_W-1:0]   fill_bits, fill_bits_next;
  logic [COUNT_W-1:0]  entry_count, entry_count_next;
  logic [31:0]         tail_word, tail_word_next;

  logic                is_append, is_read, is_restart;
  logic [4:0]          off;
  logic [WAW:0]        wcur, wnext;
  logic [FILL_W:0]     fill_sum;
  logic                append_ok, do_write;
  logic [5:0]          span;
  logic                crosses, spill, cur_even;
  logic [VALUE_W-1:0]  field_l;
  logic [63:0]         ext, joined;
  logic [31:0]         keep;

  logic [POS_W-1:0]    pos;
  logic [INDEX_W-1:0]  rw, rd_base, rd_up;
  logic                read_ok;
  status_t             status;

  always_comb begin
    is_append  = 1'b0;
    is_read    = 1'b0;
    is_restart = 1'b0;
    unique case (req.cmd)
      CMD_APPEND:  is_append  = 1'b1;
      CMD_READ:    is_read    = 1'b1;
      CMD_RESTART: is_restart = 1'b1;
      default: ;
    endcase
  end

  // append packing: field left-aligned, then shifted down to the fill offset
  assign off       = fill_bits[4:0];
  assign wcur      = fill_bits[FILL_W-1:5];
  assign wnext     = wcur + (WAW+1)'(1);
  assign fill_sum  = {1'b0, fill_bits} + (FILL_W+1)'(field_width);
  assign append_ok = (entry_count < MAX_FIELDS) && (fill_sum <= CAPACITY);
  assign do_write  = fire && is_append && append_ok && (field_width != '0);
  assign span      = {1'b0, off} + {1'b0, field_width};
  assign crosses   = span > 6'd32;
  assign spill     = span >= 6'd32;
  assign cur_even  = !wcur[0];
  assign field_l   = req.value << (5'd31 - field_width);
  assign ext       = {field_l, 33'b0} >> off;
  // tail_word holds the partly filled word; bits below the offset are dead
  assign keep      = tail_word & ~(32'hFFFF_FFFF >> off);
  assign joined    = {keep, 32'b0} | ext;

  assign even_we    = do_write && (cur_even || crosses);
  assign even_waddr = cur_even ? BANK_AW'(wcur >> 1) : BANK_AW'(wnext >> 1);
  assign even_wdata = cur_even ? joined[63:32] : joined[31:0];
  assign odd_we     = do_write && (!cur_even || crosses);
  assign odd_waddr  = cur_even ? BANK_AW'(wnext >> 1) : BANK_AW'(wcur >> 1);
  assign odd_wdata  = cur_even ? joined[31:0] : joined[63:32];

  // read address: first word and the one after it sit in opposite banks
  assign pos     = POS_W'(req.index) * POS_W'(field_width);
  assign rw      = pos[POS_W-1:5];
  assign rd_base = rw >> 1;
  assign rd_up   = rd_base + INDEX_W'(1);
  assign read_ok = {1'b0, req.index} < entry_count;

  assign rd_en      = fire && is_read;
  assign even_raddr = rw[0] ? BANK_AW'(rd_up) : BANK_AW'(rd_base);
  assign odd_raddr  = BANK_AW'(rd_base);

  always_comb begin
    status = ST_OK;
    if (is_append && !append_ok) begin
      status = ST_FULL;
    end else if (is_read && !read_ok) begin
      status = ST_RANGE;
    end
  end

  always_comb begin
    fill_bits_next   = fill_bits;
    entry_count_next = entry_count;
    tail_word_next   = tail_word;
    if (is_append && append_ok) begin
      fill_bits_next   = fill_sum[FILL_W-1:0];
      entry_count_next = entry_count + COUNT_W'(1);
      if (field_width != '0) begin
        tail_word_next = spill ? joined[31:0] : joined[63:32];
      end
    end else if (is_restart) begin
      fill_bits_next   = '0;
      entry_count_next = '0;
    end
  end

  always_comb begin
    info.extract = is_read && read_ok && (field_width != '0);
    info.odd     = rw[0];
    info.hi_ok   = 17'(rw) < DEPTH_17;
    info.lo_ok   = (17'(rw) + 17'd1) < DEPTH_17;
    info.off     = pos[4:0];
    info.fw      = field_width;
    info.status  = status;
    info.count   = entry_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_width <= RESET_FIELD_WIDTH;
    end else if (cfg_write_en) begin
      field_width <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_bits   <= '0;
      entry_count <= '0;
    end else if (fire) begin
      fill_bits   <= fill_bits_next;
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tail_word <= tail_word_next;
    end
  end

endmodule

/* hw/rtl/pfa_extract.sv */
// Field extraction from the two bank words of a read.
// Depends on pfa_pkg.
module pfa_extract
  import pfa_pkg::*;
(
  input  logic [31:0] even_rdata,
  input  logic [31:0] odd_rdata,
  input  pfa_info_t   info,
  output pfa_rsp_t    rsp
);

  logic [31:0]        hi, lo;
  logic [63:0]        aligned;
  logic [VALUE_W-1:0] field;

  // words past the end of the store read as zero
  assign hi      = !info.hi_ok ? 32'd0 : (info.odd ? odd_rdata : even_rdata);
  assign lo      = !info.lo_ok ? 32'd0 : (info.odd ? even_rdata : odd_rdata);
  assign aligned = {hi, lo} << info.off;
  assign field   = aligned[63:33] >> (5'd31 - info.fw);

  always_comb begin
    rsp.read_value  = info.extract ? field : '0;
    rsp.status      = info.status;
    rsp.field_count = info.count;
  end

endmodule

/* hw/rtl/packed_field_array.sv */
// Top level of the packed field array: pipeline control around the request
// stage, two word banks and the extraction logic. Depends on pfa_pkg.
//
// Usage:
//   Requests (cmd, value, index) enter on req with req_valid/req_ready; one
//   response (read_value, status, field_count) leaves per request on rsp
//   with rsp_valid/rsp_ready, in request order.
//   Fields are packed MSB first into 32-bit words held in an even and an
//   odd bank, so the two words a field can touch are read in the same cycle.
//   A request passes the request, bank read/info and response registers.
//   Throughput: one request per cycle while rsp_ready is high; appends keep
//   the partly filled word in a register, so no bank read is needed to pack.
//   The field width is written through cfg_write_en/cfg_write_data and must
//   only change while no request is in flight.
//   Reset empties the store and sets the field width to 8. Bank contents
//   are not cleared; reads never return bits that were not appended.
//   When the receiver holds rsp_ready low, the three stages fill and then
//   req_ready drops; nothing is lost or repeated.
module packed_field_array
  import pfa_pkg::*;
#(
  parameter int WORD_DEPTH = DEF_WORD_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [FWIDTH_W-1:0] cfg_write_data,
  input  logic                req_valid,
  output logic                req_ready,
  input  pfa_req_t            req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output pfa_rsp_t            rsp
);

  localparam int BANK_DEPTH = (WORD_DEPTH + 1) / 2;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic      v1, v2, v3;
  logic      adv1, adv2, adv3, fire;
  pfa_req_t  req_q;
  pfa_info_t info_d, info_q;
  pfa_rsp_t  rsp_d, rsp_q;

  logic               even_we, odd_we, rd_en;
  logic [BANK_AW-1:0] even_waddr, odd_waddr, even_raddr, odd_raddr;
  logic [31:0]        even_wdata, odd_wdata, even_rdata, odd_rdata;

  assign adv3      = !v3 || rsp_ready;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign fire      = v1 && adv2;
  assign req_ready = adv1;
  assign rsp_valid = v3;
  assign rsp       = rsp_q;

  pfa_issue #(
    .WORD_DEPTH (WORD_DEPTH),
    .BANK_AW    (BANK_AW)
  ) u_issue (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .req            (req_q),
    .fire           (fire),
    .even_we        (even_we),
    .even_waddr     (even_waddr),
    .even_wdata     (even_wdata),
    .odd_we         (odd_we),
    .odd_waddr      (odd_waddr),
    .odd_wdata      (odd_wdata),
    .rd_en          (rd_en),
    .even_raddr     (even_raddr),
    .odd_raddr      (odd_raddr),
    .info           (info_d)
  );

  pfa_bank #(
    .DEPTH (BANK_DEPTH),
    .AW    (BANK_AW)
  ) u_even (
    .clk   (clk),
    .we    (even_we),
    .waddr (even_waddr),
    .wdata (even_wdata),
    .re    (rd_en),
    .raddr (even_raddr),
    .rdata (even_rdata)
  );

  pfa_bank #(
    .DEPTH (BANK_DEPTH),
    .AW    (BANK_AW)
  ) u_odd (
    .clk   (clk),
    .we    (odd_we),
    .waddr (odd_waddr),
    .wdata (odd_wdata),
    .re    (rd_en),
    .raddr (odd_raddr),
    .rdata (odd_rdata)
  );

  pfa_extract u_extract (
    .even_rdata (even_rdata),
    .odd_rdata  (odd_rdata),
    .info       (info_q),
    .rsp        (rsp_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= req_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && adv1) begin
      req_q <= req;
    end
    if (fire) begin
      info_q <= info_d;
    end
    if (v2 && adv3) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

/* hw/rtl/pfa_checker.sv */
// Port-level checks for the packed field array, bound to the top level.
// Depends on pfa_pkg and packed_field_array.
module pfa_checker
  import pfa_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     req_ready,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input pfa_rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp))
    else $error("response changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> (rsp.read_value == '0))
    else $error("failed request returned a nonzero value");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.field_count <= MAX_FIELDS))
    else $error("field count above maximum");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request stalled with empty output");

endmodule

bind packed_field_array pfa_checker u_pfa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
